FILE: rtl/lsrc_pkg.sv
// Shared types and constants of the laser stripe row centroid block.
`default_nettype none
package lsrc_pkg;

    localparam int unsigned CMP_W      = 14;
    localparam int unsigned ROW_Y_W    = 13;
    localparam int unsigned CENTER_W   = 21;
    localparam int unsigned MIN_WEIGHT = 200;
    localparam int unsigned QDEPTH     = 4;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_FIRST  = 3'd0,
        REG_ROW_STOP   = 3'd1,
        REG_COL_FIRST  = 3'd2,
        REG_COL_STOP   = 3'd3,
        REG_GRAY_FLOOR = 3'd4,
        REG_ORIGIN_X   = 3'd5,
        REG_ORIGIN_Y   = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic [11:0] row_first;
        logic [12:0] row_stop;
        logic [10:0] col_first;
        logic [11:0] col_stop;
        logic [7:0]  gray_floor;
        logic [11:0] origin_x;
        logic [11:0] origin_y;
    } cfg_t;

endpackage
`default_nettype wire

FILE: rtl/lsrc_queue.sv
// Four-entry job queue between the pixel front end and the divider back end.
`default_nettype none
module lsrc_queue #(
    parameter int unsigned DW = 69
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire logic [DW-1:0] push_data,
    output logic               full,
    input  wire logic          pop,
    output logic               empty,
    output logic [DW-1:0]      pop_data
);
    localparam int unsigned PW = $clog2(lsrc_pkg::QDEPTH);

    logic [DW-1:0] mem_reg [lsrc_pkg::QDEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]   count_reg;

    assign full     = (count_reg == (PW+1)'(lsrc_pkg::QDEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push && !full) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop && !empty) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if ((push && !full) && !(pop && !empty)) begin
                count_reg <= count_reg + 1'b1;
            end else if (!(push && !full) && (pop && !empty)) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

FILE: rtl/lsrc_front.sv
// Pixel front end: line store, row sums and selection of the rows to finish.
`default_nettype none
module lsrc_front #(
    parameter int unsigned MAX_WIDTH  = 2048,
    parameter int unsigned MAX_HEIGHT = 4096,
    parameter int unsigned CW         = 11,
    parameter int unsigned RW         = 12,
    parameter int unsigned WSW        = 22,
    parameter int unsigned PSW        = 33,
    parameter int unsigned JW         = 69
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire lsrc_pkg::cfg_t cfg,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire logic [7:0]     s_pixel,
    input  wire logic           s_end_of_line,
    input  wire logic           s_end_of_frame,
    output logic                q_push,
    output logic [JW-1:0]       q_data,
    input  wire logic           q_full
);
    localparam int unsigned AW = CW + 2;
    localparam int unsigned CPW = lsrc_pkg::CMP_W;

    typedef enum logic [1:0] {
        ST_RUN  = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    logic [7:0] store_mem [2**AW];

    state_t   state_reg, state_next;
    logic [1:0] idx_reg, idx_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;

    logic          b_valid_reg;
    logic [7:0]    b_pixel_reg, rd1_reg, rd2_reg;
    logic          b_end_reg, b_eof_reg, b_colin_reg, b_rowin_reg, b_flush_reg;
    logic          b_int0_reg, b_int1_reg, b_int2_reg, b_ge1_reg, b_ge2_reg;
    logic [RW-1:0] b_r_reg;
    logic [CW-1:0] b_n_reg;

    logic [WSW-1:0] ws_reg [3];
    logic [PSW-1:0] ps_reg [3];
    logic [WSW-1:0] ws_next [3];
    logic [PSW-1:0] ps_next [3];

    logic accept;
    logic [CPW-1:0] r_x, rf_x, rs_x;
    logic [12:0] n_x;
    logic row_in, col_in;
    logic [1:0] r_m1, r_m2;

    logic [10:0] w0;
    logic [2:0] en, qual;
    logic cur_q, cur_last, finish;
    logic [CPW-1:0] m_row;

    assign s_ready = (state_reg == ST_RUN) && !(b_valid_reg && b_end_reg);
    assign accept  = s_valid && s_ready;

    assign r_x  = CPW'(row_reg);
    assign rf_x = CPW'(cfg.row_first);
    assign rs_x = CPW'(cfg.row_stop);
    assign n_x  = 13'(col_reg);
    assign row_in = (r_x >= rf_x) && (r_x < rs_x);
    assign col_in = (n_x >= 13'(cfg.col_first)) && (n_x < 13'(cfg.col_stop));
    assign r_m1 = row_reg[1:0] - 2'd1;
    assign r_m2 = row_reg[1:0] - 2'd2;

    // Line store: written with the current row, read at the two rows above.
    always_ff @(posedge aclk) begin
        if (accept) begin
            store_mem[{row_reg[1:0], col_reg}] <= s_pixel;
            rd1_reg <= store_mem[{r_m1, col_reg}];
            rd2_reg <= store_mem[{r_m2, col_reg}];
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            b_pixel_reg <= s_pixel;
            b_end_reg   <= s_end_of_line || s_end_of_frame;
            b_eof_reg   <= s_end_of_frame;
            b_r_reg     <= row_reg;
            b_n_reg     <= col_reg;
            b_rowin_reg <= row_in;
            b_colin_reg <= row_in && col_in;
            b_flush_reg <= row_in && (r_x + 1'b1 == rs_x);
            b_ge1_reg   <= r_x >= rf_x + 1'b1;
            b_ge2_reg   <= r_x >= rf_x + CPW'(2);
            b_int0_reg  <= (r_x >= rf_x + CPW'(2)) && (r_x + CPW'(2) < rs_x);
            b_int1_reg  <= (r_x >= CPW'(1)) && (r_x >= rf_x + CPW'(3))
                           && (r_x + CPW'(1) < rs_x);
            b_int2_reg  <= (r_x >= CPW'(2)) && (r_x >= rf_x + CPW'(4))
                           && (r_x < rs_x);
        end
    end

    assign w0 = b_int0_reg ? (11'(b_pixel_reg) + 11'(rd1_reg) + 11'(rd2_reg))
                           : 11'(b_pixel_reg);

    // Rows that may finish on this end of line, oldest first.
    assign en[2] = b_flush_reg ? b_ge2_reg : (b_rowin_reg && b_ge2_reg);
    assign en[1] = b_flush_reg && b_ge1_reg;
    assign en[0] = b_flush_reg;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            qual[i] = en[i] && (ws_reg[i] >= WSW'(lsrc_pkg::MIN_WEIGHT));
        end
    end

    always_comb begin
        unique case (idx_reg)
            2'd2: begin
                cur_q    = qual[2];
                cur_last = !qual[1] && !qual[0];
            end
            2'd1: begin
                cur_q    = qual[1];
                cur_last = !qual[0];
            end
            default: begin
                cur_q    = qual[0];
                cur_last = 1'b1;
            end
        endcase
    end

    assign m_row  = CPW'(b_r_reg) - CPW'(idx_reg);
    assign q_push = (state_reg == ST_EMIT) && cur_q && !q_full;
    assign q_data = {lsrc_pkg::ROW_Y_W'(m_row + CPW'(cfg.origin_y)),
                     ws_reg[idx_reg], ps_reg[idx_reg], cur_last};
    assign finish = (state_reg == ST_EMIT) && (!cur_q || !q_full)
                    && ((idx_reg == 2'd0) || (!b_flush_reg && idx_reg == 2'd2));

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        for (int i = 0; i < 3; i++) begin
            ws_next[i] = ws_reg[i];
            ps_next[i] = ps_reg[i];
        end

        if (accept) begin
            if (s_end_of_frame) begin
                row_next = '0;
                col_next = '0;
            end else if (s_end_of_line) begin
                row_next = (row_reg == RW'(MAX_HEIGHT - 1)) ? '0 : row_reg + 1'b1;
                col_next = '0;
            end else begin
                col_next = (col_reg == CW'(MAX_WIDTH - 1)) ? '0 : col_reg + 1'b1;
            end
        end

        if (b_valid_reg) begin
            if (b_colin_reg) begin
                if (b_pixel_reg > cfg.gray_floor) begin
                    ws_next[0] = ws_reg[0] + WSW'(w0);
                    ps_next[0] = ps_reg[0] + PSW'(w0 * b_n_reg);
                end
                if (b_int1_reg && rd1_reg > cfg.gray_floor) begin
                    ws_next[1] = ws_reg[1] + WSW'(b_pixel_reg);
                    ps_next[1] = ps_reg[1] + PSW'(b_pixel_reg * b_n_reg);
                end
                if (b_int2_reg && rd2_reg > cfg.gray_floor) begin
                    ws_next[2] = ws_reg[2] + WSW'(b_pixel_reg);
                    ps_next[2] = ps_reg[2] + PSW'(b_pixel_reg * b_n_reg);
                end
            end
            if (b_end_reg) begin
                state_next = ST_EMIT;
                idx_next   = 2'd2;
            end
        end

        if (state_reg == ST_EMIT && (!cur_q || !q_full)) begin
            if (finish) begin
                state_next = ST_RUN;
                if (b_flush_reg || b_eof_reg) begin
                    for (int i = 0; i < 3; i++) begin
                        ws_next[i] = '0;
                        ps_next[i] = '0;
                    end
                end else begin
                    ws_next[2] = ws_reg[1];
                    ps_next[2] = ps_reg[1];
                    ws_next[1] = ws_reg[0];
                    ps_next[1] = ps_reg[0];
                    ws_next[0] = '0;
                    ps_next[0] = '0;
                end
            end else begin
                idx_next = idx_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_RUN;
            idx_reg     <= 2'd2;
            row_reg     <= '0;
            col_reg     <= '0;
            b_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                ws_reg[i] <= '0;
                ps_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            b_valid_reg <= accept;
            for (int i = 0; i < 3; i++) begin
                ws_reg[i] <= ws_next[i];
                ps_reg[i] <= ps_next[i];
            end
        end
    end
endmodule
`default_nettype wire

FILE: rtl/lsrc_back.sv
// Divider back end: rounds the position sum over the weight and adds the origin.
`default_nettype none
module lsrc_back #(
    parameter int unsigned WSW       = 22,
    parameter int unsigned PSW       = 33,
    parameter int unsigned FRAC_BITS = 8,
    parameter int unsigned JW        = 69
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire lsrc_pkg::cfg_t cfg,
    input  wire logic           q_empty,
    input  wire logic [JW-1:0]  q_data,
    output logic                q_pop,
    output logic                m_valid,
    input  wire logic           m_ready,
    output logic [lsrc_pkg::ROW_Y_W-1:0]  m_row_y,
    output logic [lsrc_pkg::CENTER_W-1:0] m_center_x_q8,
    output logic                m_last
);
    localparam int unsigned NUMW = PSW + FRAC_BITS + 1;
    localparam int unsigned CNTW = $clog2(NUMW + 1);
    localparam int unsigned YW   = lsrc_pkg::ROW_Y_W;
    localparam int unsigned OW   = lsrc_pkg::CENTER_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_FIN  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t         state_reg;
    logic [NUMW-1:0] num_reg;
    logic [WSW-1:0]  div_reg, rem_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [YW-1:0]   row_reg;
    logic            last_reg;
    logic [OW-1:0]   center_reg;

    logic [YW-1:0]  j_row;
    logic [WSW-1:0] j_w;
    logic [PSW-1:0] j_s;
    logic           j_last;
    logic [WSW:0]   trial;
    logic           qbit;

    assign {j_row, j_w, j_s, j_last} = q_data;
    assign q_pop = (state_reg == ST_IDLE) && !q_empty;

    // One quotient bit per cycle, restoring division.
    assign trial = {rem_reg, num_reg[NUMW-1]};
    assign qbit  = trial >= {1'b0, div_reg};

    assign m_valid       = (state_reg == ST_OUT);
    assign m_row_y       = row_reg;
    assign m_center_x_q8 = center_reg;
    assign m_last        = last_reg;

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                num_reg  <= (NUMW'(j_s) << FRAC_BITS) + NUMW'(j_w >> 1);
                div_reg  <= j_w;
                rem_reg  <= '0;
                cnt_reg  <= CNTW'(NUMW);
                row_reg  <= j_row;
                last_reg <= j_last;
            end
            ST_DIV: begin
                rem_reg <= qbit ? WSW'(trial - {1'b0, div_reg}) : WSW'(trial);
                num_reg <= {num_reg[NUMW-2:0], qbit};
                cnt_reg <= cnt_reg - 1'b1;
            end
            ST_FIN: begin
                center_reg <= OW'(num_reg) + (OW'(cfg.origin_x) << FRAC_BITS);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            unique case (state_reg)
                ST_IDLE: if (!q_empty) state_reg <= ST_DIV;
                ST_DIV:  if (cnt_reg == CNTW'(1)) state_reg <= ST_FIN;
                ST_FIN:  state_reg <= ST_OUT;
                ST_OUT:  if (m_ready) state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: rtl/laser_stripe_row_centroid.sv
// Top level of the laser stripe row centroid block.
// Pixels are taken one per clock; a pixel that ends a line or a frame holds the
// input while the front end selects the finished rows, and longer if the
// four-entry job queue is full. Each emitted row costs the back end its serial
// divider, one quotient bit per cycle over a PSW + FRAC_BITS + 1 bit dividend,
// plus its load and finish states, then the result waits for m_ready.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must write it only while the block is idle, which the block does not enforce.
`default_nettype none
module laser_stripe_row_centroid #(
    parameter int unsigned MAX_WIDTH  = 2048,
    parameter int unsigned MAX_HEIGHT = 4096,
    parameter int unsigned FRAC_BITS  = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [lsrc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lsrc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_pixel,
    input  wire logic        s_end_of_line,
    input  wire logic        s_end_of_frame,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [lsrc_pkg::ROW_Y_W-1:0]  m_row_y,
    output logic [lsrc_pkg::CENTER_W-1:0] m_center_x_q8,
    output logic             m_last
);
    localparam int unsigned CW  = $clog2(MAX_WIDTH);
    localparam int unsigned RW  = $clog2(MAX_HEIGHT);
    localparam int unsigned WSW = 11 + CW;
    localparam int unsigned PSW = WSW + CW;
    localparam int unsigned JW  = lsrc_pkg::ROW_Y_W + WSW + PSW + 1;

    lsrc_pkg::cfg_t cfg_reg;
    logic           q_push, q_pop, q_full, q_empty;
    logic [JW-1:0]  q_in, q_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.row_first  <= 12'd0;
            cfg_reg.row_stop   <= 13'd4096;
            cfg_reg.col_first  <= 11'd0;
            cfg_reg.col_stop   <= 12'd2048;
            cfg_reg.gray_floor <= 8'd0;
            cfg_reg.origin_x   <= 12'd0;
            cfg_reg.origin_y   <= 12'd0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                lsrc_pkg::REG_ROW_FIRST:  cfg_reg.row_first  <= cfg_data[11:0];
                lsrc_pkg::REG_ROW_STOP:   cfg_reg.row_stop   <= cfg_data[12:0];
                lsrc_pkg::REG_COL_FIRST:  cfg_reg.col_first  <= cfg_data[10:0];
                lsrc_pkg::REG_COL_STOP:   cfg_reg.col_stop   <= cfg_data[11:0];
                lsrc_pkg::REG_GRAY_FLOOR: cfg_reg.gray_floor <= cfg_data[7:0];
                lsrc_pkg::REG_ORIGIN_X:   cfg_reg.origin_x   <= cfg_data[11:0];
                lsrc_pkg::REG_ORIGIN_Y:   cfg_reg.origin_y   <= cfg_data[11:0];
                default: begin
                end
            endcase
        end
    end

    lsrc_front #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
        .CW(CW), .RW(RW), .WSW(WSW), .PSW(PSW), .JW(JW)
    ) u_front (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg),
        .s_valid(s_valid), .s_ready(s_ready), .s_pixel(s_pixel),
        .s_end_of_line(s_end_of_line), .s_end_of_frame(s_end_of_frame),
        .q_push(q_push), .q_data(q_in), .q_full(q_full)
    );

    lsrc_queue #(.DW(JW)) u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(q_push), .push_data(q_in), .full(q_full),
        .pop(q_pop), .empty(q_empty), .pop_data(q_out)
    );

    lsrc_back #(
        .WSW(WSW), .PSW(PSW), .FRAC_BITS(FRAC_BITS), .JW(JW)
    ) u_back (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg),
        .q_empty(q_empty), .q_data(q_out), .q_pop(q_pop),
        .m_valid(m_valid), .m_ready(m_ready), .m_row_y(m_row_y),
        .m_center_x_q8(m_center_x_q8), .m_last(m_last)
    );
endmodule
`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for the laser stripe row centroid block.
`default_nettype none
module testbench;

    localparam int unsigned STORE_W = 2048;
    localparam int unsigned YW      = lsrc_pkg::ROW_Y_W;
    localparam int unsigned OW      = lsrc_pkg::CENTER_W;
    localparam int unsigned IW      = lsrc_pkg::CFG_IDX_W;
    localparam int unsigned DW      = lsrc_pkg::CFG_DATA_W;

    typedef struct {
        logic [YW-1:0] row_y;
        logic [OW-1:0] center;
        logic          last;
    } center_point_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [IW-1:0]         cfg_index = '0;
    logic [DW-1:0]         cfg_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_pixel = '0;
    logic                  s_end_of_line = 1'b0;
    logic                  s_end_of_frame = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [YW-1:0]         m_row_y;
    logic [OW-1:0]         m_center_x_q8;
    logic                  m_last;

    laser_stripe_row_centroid dut (.*);

    always #4 aclk = ~aclk;

    // Mirror of the block: configuration, line store and per-row sums.
    int unsigned    win_row_first, win_row_stop, win_col_first, win_col_stop;
    int unsigned    thresh, org_x, org_y;
    logic [7:0]     lines [4][STORE_W];
    int unsigned    filled [4];
    longint unsigned wt_sum [3];
    longint unsigned pos_sum [3];
    int unsigned    cur_row, cur_col;

    center_point_t  pending_points [$];
    int             errors = 0;
    int             items_sent = 0;
    int             send_idle_pct = 0;
    int             recv_idle_pct = 0;
    int             hold_cycles = 0;

    task automatic report(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic bit interior_row(input int unsigned m);
        return m >= win_row_first + 2 && m + 2 < win_row_stop;
    endfunction

    function automatic void emit_center(input int age, input int unsigned m, inout int count);
        center_point_t pt;
        longint unsigned w, q;
        w = wt_sum[age];
        if (w < lsrc_pkg::MIN_WEIGHT)
            return;
        q = ((pos_sum[age] << 8) + (w >> 1)) / w + (longint'(org_x) << 8);
        pt.row_y  = YW'(m + org_y);
        pt.center = OW'(q);
        pt.last   = 1'b0;
        pending_points = {pending_points, pt};
        count++;
    endfunction

    function automatic void clear_sums();
        for (int i = 0; i < 3; i++) begin
            wt_sum[i] = 0;
            pos_sum[i] = 0;
        end
    endfunction

    function automatic void predict_pixel(input logic [7:0] p, input logic eol, input logic eof);
        int unsigned r, n;
        bit row_in;
        int count;
        longint unsigned w;
        r = cur_row;
        n = cur_col;
        row_in = r >= win_row_first && r < win_row_stop;
        count = 0;
        if (row_in && n >= win_col_first && n < win_col_stop) begin
            if (p > thresh) begin
                w = p;
                if (interior_row(r))
                    w += lines[(r - 1) & 3][n] + lines[(r - 2) & 3][n];
                wt_sum[0] += w;
                pos_sum[0] += w * n;
            end
            if (r >= 1 && interior_row(r - 1) && lines[(r - 1) & 3][n] > thresh) begin
                wt_sum[1] += p;
                pos_sum[1] += longint'(p) * n;
            end
            if (r >= 2 && interior_row(r - 2) && lines[(r - 2) & 3][n] > thresh) begin
                wt_sum[2] += p;
                pos_sum[2] += longint'(p) * n;
            end
        end
        lines[r & 3][n] = p;
        if (filled[r & 3] < n + 1)
            filled[r & 3] = n + 1;
        if (eol || eof) begin
            if (row_in && r + 1 == win_row_stop) begin
                if (r >= win_row_first + 2)
                    emit_center(2, r - 2, count);
                if (r >= win_row_first + 1)
                    emit_center(1, r - 1, count);
                emit_center(0, r, count);
                clear_sums();
            end else begin
                if (row_in && r >= win_row_first + 2)
                    emit_center(2, r - 2, count);
                wt_sum[2] = wt_sum[1];
                pos_sum[2] = pos_sum[1];
                wt_sum[1] = wt_sum[0];
                pos_sum[1] = pos_sum[0];
                wt_sum[0] = 0;
                pos_sum[0] = 0;
            end
            cur_row = (r + 1) % 4096;
            cur_col = 0;
        end else begin
            cur_col = (n + 1) % STORE_W;
        end
        if (eof) begin
            clear_sums();
            cur_row = 0;
            cur_col = 0;
        end
        if (count > 0)
            pending_points[$].last = 1'b1;
    endfunction

    task automatic write_reg(input lsrc_pkg::reg_index_t idx, input int unsigned value);
        @(negedge aclk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = DW'(value);
        @(negedge aclk);
        cfg_we = 1'b0;
        case (idx)
            lsrc_pkg::REG_ROW_FIRST:  win_row_first = value & 12'hFFF;
            lsrc_pkg::REG_ROW_STOP:   win_row_stop = value & 13'h1FFF;
            lsrc_pkg::REG_COL_FIRST:  win_col_first = value & 11'h7FF;
            lsrc_pkg::REG_COL_STOP:   win_col_stop = value & 12'hFFF;
            lsrc_pkg::REG_GRAY_FLOOR: thresh = value & 8'hFF;
            lsrc_pkg::REG_ORIGIN_X:   org_x = value & 12'hFFF;
            lsrc_pkg::REG_ORIGIN_Y:   org_y = value & 12'hFFF;
            default: ;
        endcase
    endtask

    task automatic set_window(input int unsigned rf, input int unsigned rs, input int unsigned cf,
                              input int unsigned cs, input int unsigned mg, input int unsigned ox,
                              input int unsigned oy);
        write_reg(lsrc_pkg::REG_ROW_FIRST, rf);
        write_reg(lsrc_pkg::REG_ROW_STOP, rs);
        write_reg(lsrc_pkg::REG_COL_FIRST, cf);
        write_reg(lsrc_pkg::REG_COL_STOP, cs);
        write_reg(lsrc_pkg::REG_GRAY_FLOOR, mg);
        write_reg(lsrc_pkg::REG_ORIGIN_X, ox);
        write_reg(lsrc_pkg::REG_ORIGIN_Y, oy);
    endtask

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_pixel(input logic [7:0] p, input logic eol, input logic eof);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_pixel = p;
        s_end_of_line = eol;
        s_end_of_frame = eof;
        do @(posedge aclk); while (!s_ready);
        predict_pixel(p, eol, eof);
        items_sent++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    // Wait until the block has drained, then allow for rows still in the divider.
    task automatic wait_idle();
        while (pending_points.size() != 0)
            @(posedge aclk);
        repeat (250) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Random row length that only reads store entries written before.
    function automatic int unsigned pick_len(input int unsigned wmax);
        int unsigned bound;
        bound = wmax;
        if (cur_row >= 1 && filled[(cur_row - 1) & 3] < bound)
            bound = filled[(cur_row - 1) & 3];
        if (cur_row >= 2 && filled[(cur_row - 2) & 3] < bound)
            bound = filled[(cur_row - 2) & 3];
        return $urandom_range(bound, 1);
    endfunction

    // One row with a bright stripe near column peak; noisy rows are fully random.
    task automatic send_row(input int unsigned len, input int unsigned peak,
                            input bit noisy, input bit frame_end);
        logic [7:0] p;
        for (int unsigned n = 0; n < len; n++) begin
            if (noisy)
                p = 8'($urandom);
            else if (n + 2 >= peak && n <= peak + 2)
                p = 8'($urandom_range(255, 120));
            else
                p = 8'($urandom_range(30, 0));
            send_pixel(p, n == len - 1, frame_end && n == len - 1);
        end
    endtask

    task automatic send_frame(input int unsigned rows, input int unsigned wmax, input int noise_pct);
        int unsigned len;
        for (int unsigned r = 0; r < rows; r++) begin
            len = pick_len(wmax);
            if (r == rows - 1 && $urandom_range(9, 0) == 0) begin
                // The frame ends in the middle of a row.
                send_row(len, $urandom_range(len, 0), 1'b0, 1'b0);
                len = pick_len(wmax);
                for (int unsigned n = 0; n < len; n++)
                    send_pixel(8'($urandom), 1'b0, n == len - 1);
            end else begin
                send_row(len, $urandom_range(len, 0), $urandom_range(99, 0) < noise_pct,
                         r == rows - 1);
            end
        end
    endtask

    task automatic test_defaults();
        // Fill all four store rows under the reset window.
        for (int r = 0; r < 6; r++)
            send_row(8, 1 + r, 1'b0, r == 5);
        wait_idle();
    endtask

    task automatic test_window_extremes();
        set_window(0, 5, 0, 2048, 0, 4095, 4095);
        send_frame(6, 32, 0);
        wait_idle();
        set_window(4095, 4096, 2047, 2048, 255, 0, 0);
        send_frame(3, 32, 0);
        wait_idle();
        set_window(3, 3, 5, 2, 0, 0, 0);
        send_frame(4, 16, 0);
        wait_idle();
        set_window(0, 0, 0, 0, 0, 0, 0);
        send_frame(2, 8, 0);
        wait_idle();
        // Saturated stripe pixels next to zeros.
        set_window(1, 8, 1, 7, 254, 17, 9);
        for (int r = 0; r < 9; r++)
            for (int n = 0; n < 8; n++)
                send_pixel((n == 3 || n == 4) ? 8'hFF : 8'h00, n == 7, r == 8 && n == 7);
        wait_idle();
    endtask

    task automatic test_threshold_change();
        set_window(0, 10, 0, 2048, 40, 3, 1);
        for (int r = 0; r < 4; r++)
            send_row(8, 4, 1'b0, 1'b0);
        wait_idle();
        // Pending rows keep their sums; later pixels are judged against the new threshold.
        write_reg(lsrc_pkg::REG_GRAY_FLOOR, 200);
        for (int r = 0; r < 6; r++)
            send_row(8, 4, 1'b0, r == 5);
        wait_idle();
    endtask

    task automatic test_backpressure();
        set_window(0, 4096, 0, 2048, 10, 100, 200);
        hold_cycles = 600;
        send_frame(20, 6, 0);
        wait_idle();
    endtask

    task automatic test_random(input int unsigned items);
        int unsigned goal;
        int unsigned rf, cf;
        goal = items_sent + items;
        while (items_sent < goal) begin
            rf = $urandom_range(4, 0);
            cf = $urandom_range(6, 0);
            set_window(rf, ($urandom_range(4, 0) == 0) ? 4096 : rf + $urandom_range(10, 0),
                       cf, ($urandom_range(4, 0) == 0) ? 2048 : cf + $urandom_range(30, 0),
                       ($urandom_range(9, 0) == 0) ? $urandom_range(255, 0)
                                                   : $urandom_range(100, 0),
                       $urandom_range(4095, 0), $urandom_range(4095, 0));
            send_frame($urandom_range(8, 1), $urandom_range(12, 4), 10);
            wait_idle();
        end
    endtask

    // Result side: random stalls plus a long hold-off when requested.
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        center_point_t exp_pt;
        if (aresetn && m_valid && m_ready) begin
            if (pending_points.size() == 0) begin
                report($sformatf("unexpected transaction row_y=%0d", m_row_y));
            end else begin
                exp_pt = pending_points.pop_front();
                if (m_row_y !== exp_pt.row_y)
                    report($sformatf("row_y %0d, expected %0d", m_row_y, exp_pt.row_y));
                if (m_center_x_q8 !== exp_pt.center)
                    report($sformatf("center_x_q8 %0d, expected %0d (row %0d)",
                                     m_center_x_q8, exp_pt.center, exp_pt.row_y));
                if (m_last !== exp_pt.last)
                    report($sformatf("last %0b, expected %0b (row %0d)",
                                     m_last, exp_pt.last, exp_pt.row_y));
            end
        end
    end

    initial begin
        #16000000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        win_row_first = 0;
        win_row_stop = 4096;
        win_col_first = 0;
        win_col_stop = 2048;
        thresh = 0;
        org_x = 0;
        org_y = 0;
        cur_row = 0;
        cur_col = 0;
        clear_sums();
        for (int i = 0; i < 4; i++)
            filled[i] = 0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_defaults();
        test_window_extremes();
        test_threshold_change();
        test_backpressure();
        send_idle_pct = 26;
        recv_idle_pct = 68;
        test_random(25);
        send_idle_pct = 68;
        recv_idle_pct = 26;
        test_random(25);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(25);

        wait_idle();
        if (errors == 0 && pending_points.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
`default_nettype wire

FILE: laser_stripe_row_centroid.f
rtl/lsrc_pkg.sv
rtl/lsrc_queue.sv
rtl/lsrc_front.sv
rtl/lsrc_back.sv
rtl/laser_stripe_row_centroid.sv
verif/testbench.sv
